// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the checkerboard digit pad.
// Each macro checks a property on the rising edge of i_clk and is switched
// off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent is followed by a consequent (overlapping).
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that an antecedent is later followed by a consequent.
`define ASSERT_AFTER2(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##2 (cons)) else $error(msg);

`endif

// ===== rtl/core/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// Checkerboard digit pad package
// Board tables, codes, shared types and mod-10 digit helpers.
// ----------------------------------------------------------------------------
package scd_pkg;

    // Operation kinds.
    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_DEC = 1'b1;

    // Status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_TEXT = 2'd1;
    localparam logic [1:0] STAT_KEY  = 2'd2;
    localparam logic [1:0] STAT_CODE = 2'd3;

    // High digit of the top row.
    localparam logic [3:0] TOP_DIGIT = 4'hF;
    localparam logic [3:0] MAX_DIGIT = 4'd9;

    localparam int BOARD_SIZE = 31;

    // Letters of the board, row by row.
    localparam logic [15:0] BOARD_LETTER [BOARD_SIZE] = '{
        16'h0410, 16'h0418, 16'h0422, 16'h0415, 16'h0421, 16'h041D, 16'h041E,
        16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0416, 16'h0417, 16'h041A,
        16'h041B, 16'h041C, 16'h041F,
        16'h0420, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427, 16'h0428,
        16'h0429, 16'h042A, 16'h042B,
        16'h042C, 16'h042D, 16'h042E, 16'h042F
    };

    // Code byte of each board cell: row digit, then column (ten coded as 0).
    localparam logic [7:0] BOARD_CODE [BOARD_SIZE] = '{
        8'hF1, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6, 8'hF7,
        8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h80,
        8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h90,
        8'h01, 8'h02, 8'h03, 8'h04
    };

    // Result of a letter lookup.
    typedef struct packed {
        logic       found;
        logic [7:0] code;
    } t_lookup;

    // Sum of two decimal digits, mod 10.
    function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 5'd10) begin
            s = s - 5'd10;
        end
        return s[3:0];
    endfunction

    // Difference of two decimal digits, mod 10.
    function automatic logic [3:0] sub_mod10(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] d;
        if (a >= b) begin
            d = {1'b0, a} - {1'b0, b};
        end else begin
            d = {1'b0, a} + 5'd10 - {1'b0, b};
        end
        return d[3:0];
    endfunction

endpackage

// ===== rtl/core/scd_lookup.sv =====
// ----------------------------------------------------------------------------
// Letter lookup
// Maps a code point to its checkerboard code byte, flagging unknown letters.
// ----------------------------------------------------------------------------
module scd_lookup (
    input  logic [15:0]           i_letter,
    output scd_pkg::t_lookup      o_result
);

    // Compare against every cell at once; at most one cell can match.
    always_comb begin
        o_result = '0;
        for (int i = 0; i < scd_pkg::BOARD_SIZE; i++) begin
            if (i_letter == scd_pkg::BOARD_LETTER[i]) begin
                o_result.found = 1'b1;
                o_result.code  = o_result.code | scd_pkg::BOARD_CODE[i];
            end
        end
    end

endmodule

// ===== rtl/core/scd_digit.sv =====
// ----------------------------------------------------------------------------
// Digit arithmetic
// Adds or subtracts key digits mod 10, decodes the cipher and sets status.
// ----------------------------------------------------------------------------
module scd_digit (
    input  logic                  i_kind,
    input  logic [7:0]            i_cipher_code,
    input  scd_pkg::t_lookup      i_text,
    input  scd_pkg::t_lookup      i_key,
    output logic [7:0]            o_code,
    output logic [15:0]           o_letter,
    output logic [1:0]            o_status
);

    logic [3:0]  kh;
    logic [3:0]  kl;
    logic [3:0]  th;
    logic [3:0]  ch;
    logic [3:0]  cl;
    logic [7:0]  enc_code;
    logic [7:0]  dec_code;
    logic        malformed;
    logic        dec_found;
    logic [15:0] dec_letter;

    // Key digits: a top-row key uses its column digit for both.
    always_comb begin
        kl = i_key.code[3:0];
        kh = (i_key.code[7:4] == scd_pkg::TOP_DIGIT) ? kl : i_key.code[7:4];
    end

    // Encryption: the top-row marker of the text passes unchanged.
    always_comb begin
        th = i_text.code[7:4];
        enc_code[7:4] = (th == scd_pkg::TOP_DIGIT) ? th : scd_pkg::add_mod10(th, kh);
        enc_code[3:0] = scd_pkg::add_mod10(i_text.code[3:0], kl);
    end

    // Decryption: check the cipher byte, then subtract the key digits.
    always_comb begin
        ch = i_cipher_code[7:4];
        cl = i_cipher_code[3:0];
        malformed = ((ch > scd_pkg::MAX_DIGIT) && (ch != scd_pkg::TOP_DIGIT)) ||
                    (cl > scd_pkg::MAX_DIGIT);
        dec_code[7:4] = (ch == scd_pkg::TOP_DIGIT) ? ch : scd_pkg::sub_mod10(ch, kh);
        dec_code[3:0] = scd_pkg::sub_mod10(cl, kl);
    end

    // Reverse lookup of the recovered code; empty cells do not match.
    always_comb begin
        dec_found  = 1'b0;
        dec_letter = '0;
        for (int i = 0; i < scd_pkg::BOARD_SIZE; i++) begin
            if (dec_code == scd_pkg::BOARD_CODE[i]) begin
                dec_found  = 1'b1;
                dec_letter = dec_letter | scd_pkg::BOARD_LETTER[i];
            end
        end
    end

    // Status in priority order; any error zeroes the result fields.
    always_comb begin
        o_code   = '0;
        o_letter = '0;
        o_status = scd_pkg::STAT_OK;
        if ((i_kind == scd_pkg::KIND_ENC) && !i_text.found) begin
            o_status = scd_pkg::STAT_TEXT;
        end else if (!i_key.found) begin
            o_status = scd_pkg::STAT_KEY;
        end else if (i_kind == scd_pkg::KIND_ENC) begin
            o_code = enc_code;
        end else if (malformed || !dec_found) begin
            o_status = scd_pkg::STAT_CODE;
        end else begin
            o_code   = dec_code;
            o_letter = dec_letter;
        end
    end

endmodule

// ===== rtl/core/straddling_checkerboard_digit_pad.sv =====
// ----------------------------------------------------------------------------
// Straddling checkerboard digit pad
// Encrypts or decrypts one letter per transaction over a fixed Cyrillic board.
// ----------------------------------------------------------------------------
//  Channel   Handshake                    Payload
//  input     start, accepted when !busy   i_kind, i_text_letter, i_cipher_code,
//                                         i_key_letter
//  result    o_valid, one-cycle strobe    o_code, o_letter, o_status
//
//  One transaction is accepted per cycle outside reset; its result strobes
//  after the input register and the result register.
//  busy is high only while i_rst_n is low.
//  Reset is synchronous and clears both valid flags.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module straddling_checkerboard_digit_pad (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [15:0] i_text_letter,
    input  logic [7:0]  i_cipher_code,
    input  logic [15:0] i_key_letter,
    output logic        o_valid,
    output logic [7:0]  o_code,
    output logic [15:0] o_letter,
    output logic [1:0]  o_status
);

    logic        r_vld;
    logic        r_kind;
    logic [15:0] r_text;
    logic [7:0]  r_ciph;
    logic [15:0] r_key;

    logic        r_out_vld;
    logic [7:0]  r_code;
    logic [15:0] r_letter;
    logic [1:0]  r_status;

    logic [7:0]  n_code;
    logic [15:0] n_letter;
    logic [1:0]  n_status;

    scd_pkg::t_lookup text_lk;
    scd_pkg::t_lookup key_lk;

    // The block takes a transaction in every cycle outside reset.
    assign busy = !i_rst_n;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start;
        end
        if (start && !busy) begin
            r_kind <= i_kind;
            r_text <= i_text_letter;
            r_ciph <= i_cipher_code;
            r_key  <= i_key_letter;
        end
    end

    // Board lookups for the text and key letters.
    scd_lookup u_text_lookup (
        .i_letter (r_text),
        .o_result (text_lk)
    );

    scd_lookup u_key_lookup (
        .i_letter (r_key),
        .o_result (key_lk)
    );

    // Digit arithmetic and cipher decoding.
    scd_digit u_digit (
        .i_kind        (r_kind),
        .i_cipher_code (r_ciph),
        .i_text        (text_lk),
        .i_key         (key_lk),
        .o_code        (n_code),
        .o_letter      (n_letter),
        .o_status      (n_status)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld;
        end
        if (r_vld) begin
            r_code   <= n_code;
            r_letter <= n_letter;
            r_status <= n_status;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_code   = r_code;
    assign o_letter = r_letter;
    assign o_status = r_status;

    // Every accepted transaction strobes a result after the input and result registers.
    `ASSERT_AFTER2(a_result_follows, start && !busy, o_valid, "result strobe missing")

    // An error result carries no code and no letter.
    `ASSERT_IMPLIES(a_error_zero, o_valid && (o_status != scd_pkg::STAT_OK),
        (o_code == 8'h00) && (o_letter == 16'h0000), "error result not zeroed")

    // An encryption result never carries a letter.
    `ASSERT_IMPLIES(a_enc_no_letter, o_valid && ($past(i_kind, 2) == scd_pkg::KIND_ENC),
        o_letter == 16'h0000, "encryption result carries a letter")

    // A successful decryption always recovers a letter on the board.
    `ASSERT_IMPLIES(a_dec_letter, o_valid && ($past(i_kind, 2) == scd_pkg::KIND_DEC) &&
        (o_status == scd_pkg::STAT_OK), o_letter != 16'h0000, "decryption lost its letter")

endmodule

// ===== test/straddling_checkerboard_digit_pad_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checkerboard digit pad checker
// Watches the input and result channels of the digit pad. It predicts the
// result of every accepted transaction from its own copy of the board, then
// compares each strobed result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module straddling_checkerboard_digit_pad_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_kind,
    input  logic [15:0] i_text_letter,
    input  logic [7:0]  i_cipher_code,
    input  logic [15:0] i_key_letter,
    input  logic        o_valid,
    input  logic [7:0]  o_code,
    input  logic [15:0] o_letter,
    input  logic [1:0]  o_status,
    output int          o_mismatches,
    output int          o_backlog
);

    // One predicted result transaction.
    typedef struct packed {
        logic [7:0]  code;
        logic [15:0] letter;
        logic [1:0]  status;
    } t_pad_result;

    // The board, row by row, and the row layout.
    localparam logic [15:0] GRID_LETTER [31] = '{
        16'h0410, 16'h0418, 16'h0422, 16'h0415, 16'h0421, 16'h041D, 16'h041E,
        16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0416, 16'h0417, 16'h041A,
        16'h041B, 16'h041C, 16'h041F,
        16'h0420, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427, 16'h0428,
        16'h0429, 16'h042A, 16'h042B,
        16'h042C, 16'h042D, 16'h042E, 16'h042F
    };
    localparam int         ROW_SPAN [4] = '{7, 10, 10, 4};
    localparam logic [3:0] ROW_TAG  [4] = '{4'hF, 4'h8, 4'h9, 4'h0};
    localparam int         TOP_ROW_TAG  = 15;

    t_pad_result awaited_results [$];
    int          mismatch_tally = 0;

    // Looks up the cell code of a letter; returns 0 when it is not on the board.
    function automatic logic find_cell(input logic [15:0] cp, output logic [7:0] cell_code);
        int   idx;
        logic found;
        idx = 0;
        found = 1'b0;
        cell_code = 8'h00;
        for (int r = 0; r < 4; r++) begin
            for (int c = 1; c <= ROW_SPAN[r]; c++) begin
                if (GRID_LETTER[idx] == cp) begin
                    cell_code = {ROW_TAG[r], 4'(c % 10)};
                    found = 1'b1;
                end
                idx++;
            end
        end
        return found;
    endfunction

    // Looks up the letter in a cell; returns 0 when the cell holds none.
    function automatic logic cell_letter(input logic [7:0] cell_code, output logic [15:0] cp);
        int   col;
        int   base;
        logic found;
        found = 1'b0;
        cp = 16'h0000;
        base = 0;
        if (cell_code[3:0] <= 4'd9) begin
            col = (cell_code[3:0] == 4'd0) ? 10 : int'(cell_code[3:0]);
            for (int r = 0; r < 4; r++) begin
                if (ROW_TAG[r] == cell_code[7:4] && col <= ROW_SPAN[r]) begin
                    cp = GRID_LETTER[base + col - 1];
                    found = 1'b1;
                end
                base += ROW_SPAN[r];
            end
        end
        return found;
    endfunction

    // Expected result of one transaction.
    function automatic t_pad_result checkerboard_result(input logic kind,
                                                        input logic [15:0] text,
                                                        input logic [7:0] cipher,
                                                        input logic [15:0] key);
        t_pad_result res;
        logic [7:0]  text_cell;
        logic [7:0]  key_cell;
        logic [7:0]  plain_cell;
        logic [15:0] plain;
        logic        text_ok;
        logic        key_ok;
        int          kh, kl, sh, sl;
        res = '0;
        res.status = scd_pkg::STAT_OK;
        text_ok = find_cell(text, text_cell);
        key_ok = find_cell(key, key_cell);
        if (kind == scd_pkg::KIND_ENC && !text_ok) begin
            res.status = scd_pkg::STAT_TEXT;
        end else if (!key_ok) begin
            res.status = scd_pkg::STAT_KEY;
        end else begin
            // A top-row key letter lends its column digit to both digits.
            kh = key_cell[7:4];
            kl = key_cell[3:0];
            if (kh == TOP_ROW_TAG) begin
                kh = kl;
            end
            if (kind == scd_pkg::KIND_ENC) begin
                sh = text_cell[7:4];
                sl = text_cell[3:0];
                if (sh != TOP_ROW_TAG) begin
                    sh = (sh + kh) % 10;
                end
                sl = (sl + kl) % 10;
                res.code = {4'(sh), 4'(sl)};
            end else begin
                sh = cipher[7:4];
                sl = cipher[3:0];
                if ((sh > 9 && sh != TOP_ROW_TAG) || sl > 9) begin
                    res.status = scd_pkg::STAT_CODE;
                end else begin
                    if (sh != TOP_ROW_TAG) begin
                        sh = (sh + 10 - kh) % 10;
                    end
                    sl = (sl + 10 - kl) % 10;
                    plain_cell = {4'(sh), 4'(sl)};
                    if (cell_letter(plain_cell, plain)) begin
                        res.code = plain_cell;
                        res.letter = plain;
                    end else begin
                        res.status = scd_pkg::STAT_CODE;
                    end
                end
            end
        end
        return res;
    endfunction

    // Compare strobed results first, then record the newly accepted transaction.
    always @(posedge i_clk) begin
        t_pad_result want;
        if (i_rst_n && o_valid) begin
            if (awaited_results.size() == 0) begin
                $display("[%0t] result with none awaited: code %h letter %h status %h",
                         $time, o_code, o_letter, o_status);
                mismatch_tally++;
            end else begin
                want = awaited_results.pop_front();
                if (o_code !== want.code) begin
                    $display("[%0t] code: expected %h, got %h", $time, want.code, o_code);
                    mismatch_tally++;
                end
                if (o_letter !== want.letter) begin
                    $display("[%0t] letter: expected %h, got %h",
                             $time, want.letter, o_letter);
                    mismatch_tally++;
                end
                if (o_status !== want.status) begin
                    $display("[%0t] status: expected %h, got %h",
                             $time, want.status, o_status);
                    mismatch_tally++;
                end
            end
        end
        if (start && !busy) begin
            awaited_results.push_back(checkerboard_result(i_kind, i_text_letter,
                                                          i_cipher_code, i_key_letter));
        end
        o_mismatches <= mismatch_tally;
        o_backlog <= awaited_results.size();
    end

endmodule

// ===== test/straddling_checkerboard_digit_pad_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checkerboard digit pad testbench
// Drives directed and random encrypt and decrypt transactions into the digit
// pad with varying sender gaps; the checker beside the block predicts and
// compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
module straddling_checkerboard_digit_pad_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_kind;
    logic [15:0] i_text_letter;
    logic [7:0]  i_cipher_code;
    logic [15:0] i_key_letter;
    logic        o_valid;
    logic [7:0]  o_code;
    logic [15:0] o_letter;
    logic [1:0]  o_status;
    int          mismatches;
    int          backlog;
    int          calm_left;

    straddling_checkerboard_digit_pad dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_text_letter (i_text_letter),
        .i_cipher_code (i_cipher_code),
        .i_key_letter  (i_key_letter),
        .o_valid       (o_valid),
        .o_code        (o_code),
        .o_letter      (o_letter),
        .o_status      (o_status)
    );

    straddling_checkerboard_digit_pad_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_text_letter (i_text_letter),
        .i_cipher_code (i_cipher_code),
        .i_key_letter  (i_key_letter),
        .o_valid       (o_valid),
        .o_code        (o_code),
        .o_letter      (o_letter),
        .o_status      (o_status),
        .o_mismatches  (mismatches),
        .o_backlog     (backlog)
    );

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog for a hung run.
    initial begin
        #400000;
        $display("straddling_checkerboard_digit_pad: mismatch");
        $finish;
    end

    // Mostly letters of the board's code point block, with some noise.
    function automatic logic [15:0] pick_letter();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            return 16'h0410 + 16'($urandom_range(0, 31));
        end else if (r < 93) begin
            return 16'($urandom_range(0, 65535));
        end
        return 16'h0400 + 16'($urandom_range(0, 79));
    endfunction

    // Mostly well-formed cipher bytes, with some malformed ones.
    function automatic logic [7:0] pick_cipher();
        int         r;
        logic [3:0] row_digit;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: row_digit = 4'hF;
            1: row_digit = 4'h8;
            2: row_digit = 4'h9;
            default: row_digit = 4'h0;
        endcase
        if (r < 75) begin
            return {row_digit, 4'($urandom_range(0, 9))};
        end else if (r < 85) begin
            return {4'($urandom_range(1, 7)), 4'($urandom_range(0, 9))};
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Presents one transaction, after an optional gap, and waits for its acceptance.
    task automatic send_letter(input int idle_pct, input logic kind, input logic [15:0] text,
                               input logic [7:0] cipher, input logic [15:0] key);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_kind <= kind;
        i_text_letter <= text;
        i_cipher_code <= cipher;
        i_key_letter <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Random transactions with the given gap rate, broken by calm stretches.
    task automatic random_phase(input int count, input int idle_pct);
        logic kind;
        for (int n = 0; n < count; n++) begin
            kind = ($urandom_range(0, 1) != 0) ? scd_pkg::KIND_DEC : scd_pkg::KIND_ENC;
            if (calm_left > 0) begin
                calm_left--;
                send_letter(0, kind, pick_letter(), pick_cipher(), pick_letter());
            end else begin
                if ($urandom_range(0, 99) < 5) begin
                    calm_left = $urandom_range(5, 20);
                end
                send_letter(idle_pct, kind, pick_letter(), pick_cipher(), pick_letter());
            end
        end
    endtask

    // Reset, directed cases, random phases, drain and verdict.
    initial begin
        calm_left = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_kind <= scd_pkg::KIND_ENC;
        i_text_letter <= 16'h0000;
        i_cipher_code <= 8'h00;
        i_key_letter <= 16'h0000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Encryption across the rows, with the tenth column and top-row keys.
        send_letter(0, scd_pkg::KIND_ENC, 16'h0410, 8'h00, 16'h0410);
        send_letter(0, scd_pkg::KIND_ENC, 16'h041F, 8'hFF, 16'h042F);
        send_letter(30, scd_pkg::KIND_ENC, 16'h042B, 8'h00, 16'h041E);
        send_letter(0, scd_pkg::KIND_ENC, 16'h042C, 8'hA5, 16'h0411);
        send_letter(0, scd_pkg::KIND_ENC, 16'h041E, 8'h00, 16'h042B);
        // Unknown text letter, checked ahead of an unknown key letter.
        send_letter(0, scd_pkg::KIND_ENC, 16'h0419, 8'h00, 16'h0410);
        send_letter(30, scd_pkg::KIND_ENC, 16'h0000, 8'h00, 16'hFFFF);
        send_letter(0, scd_pkg::KIND_ENC, 16'hFFFF, 8'h00, 16'h041A);
        send_letter(0, scd_pkg::KIND_ENC, 16'h0410, 8'h00, 16'h0419);
        // Decryption, including the top row passed through and row wrap.
        send_letter(0, scd_pkg::KIND_DEC, 16'h0000, 8'hF1, 16'h0410);
        send_letter(0, scd_pkg::KIND_DEC, 16'h0000, 8'hF2, 16'h0410);
        send_letter(30, scd_pkg::KIND_DEC, 16'h0000, 8'h80, 16'h042F);
        send_letter(0, scd_pkg::KIND_DEC, 16'h0000, 8'h90, 16'h041E);
        send_letter(0, scd_pkg::KIND_DEC, 16'h0000, 8'h01, 16'h0410);
        send_letter(0, scd_pkg::KIND_DEC, 16'h0000, 8'h05, 16'h042C);
        // Malformed cipher bytes.
        send_letter(0, scd_pkg::KIND_DEC, 16'h0000, 8'hA5, 16'h0410);
        send_letter(30, scd_pkg::KIND_DEC, 16'h0000, 8'hE0, 16'h0411);
        send_letter(0, scd_pkg::KIND_DEC, 16'h0000, 8'h5A, 16'h0412);
        send_letter(0, scd_pkg::KIND_DEC, 16'h0000, 8'hFF, 16'h0410);
        // Unknown key letter is reported ahead of a malformed byte.
        send_letter(0, scd_pkg::KIND_DEC, 16'h0000, 8'hAA, 16'hFFFF);
        send_letter(0, scd_pkg::KIND_DEC, 16'hFFFF, 8'h00, 16'h0000);
        // Recovered codes that fall off the board; the text letter is ignored.
        send_letter(30, scd_pkg::KIND_DEC, 16'hFFFF, 8'h81, 16'h0411);
        send_letter(0, scd_pkg::KIND_DEC, 16'h0000, 8'h12, 16'h041F);
        send_letter(0, scd_pkg::KIND_DEC, 16'h0000, 8'h06, 16'h042C);

        random_phase(250, 0);
        random_phase(250, 85);
        random_phase(250, 9);
        start <= 1'b0;

        // Drain the outstanding results, then allow for the pipeline.
        @(posedge i_clk);
        while (backlog != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && backlog == 0) begin
            $display("straddling_checkerboard_digit_pad: match");
        end else begin
            $display("straddling_checkerboard_digit_pad: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/scd_pkg.sv
rtl/core/scd_lookup.sv
rtl/core/scd_digit.sv
rtl/core/straddling_checkerboard_digit_pad.sv
test/straddling_checkerboard_digit_pad_checker.sv
test/straddling_checkerboard_digit_pad_test.sv
